/* hdl/quadrature_decoder_x4_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the x4 quadrature decoder checker
// ----------------------------------------------------------------------------
`ifndef QUADRATURE_DECODER_X4_CORE_ASSERT_SVH
`define QUADRATURE_DECODER_X4_CORE_ASSERT_SVH

// Same-cycle implication, ignored while reset is asserted.
`define QDX4_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define QDX4_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define QDX4_ASSERT_ALWAYS(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/qdx4_pkg.sv */
// ----------------------------------------------------------------------------
// qdx4_pkg
// Shared types and constants of the x4 quadrature decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package qdx4_pkg;

    localparam int NUM_COUNTERS = 4;   // relative counters, 1 to 2**IDX_W
    localparam int TIME_W       = 32;
    localparam int COUNT_W      = 32;
    localparam int IDX_W        = 2;
    localparam int STATE_W      = 2;

    typedef struct packed {
        logic              chan_a;
        logic              chan_b;
        logic [TIME_W-1:0] time_us;
        logic [IDX_W-1:0]  counter_index;
        logic              zero_counter;
    } t_sample;

    typedef struct packed {
        logic signed [COUNT_W-1:0] relative_count;
        logic [STATE_W-1:0]        channel_state;
        logic [TIME_W-1:0]         edge_period;
    } t_result;

endpackage

`default_nettype wire

/* hdl/qdx4_in_stage.sv */
// ----------------------------------------------------------------------------
// qdx4_in_stage
// Input register: holds one sample transaction until the update stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module qdx4_in_stage (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    input  qdx4_pkg::t_sample i_sample,
    input  wire               i_take,
    output logic              o_stall,
    output logic              o_valid,
    output qdx4_pkg::t_sample o_sample
);

    logic              r_valid;
    logic              n_valid;
    qdx4_pkg::t_sample r_sample;
    logic              accept;

    // full and not draining this cycle
    assign o_stall = r_valid && !i_take;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample <= i_sample;
        end
    end

    assign o_valid  = r_valid;
    assign o_sample = r_sample;

endmodule

`default_nettype wire

/* hdl/qdx4_update.sv */
// ----------------------------------------------------------------------------
// qdx4_update
// Decoder state and single-pass update: edge detect, count, period, offsets.
// ----------------------------------------------------------------------------
`default_nettype none

module qdx4_update (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_fire,
    input  qdx4_pkg::t_sample i_sample,
    output qdx4_pkg::t_result o_result
);

    logic [qdx4_pkg::STATE_W-1:0] r_prev;
    logic                         r_primed;
    logic [qdx4_pkg::COUNT_W-1:0] r_total;
    logic [qdx4_pkg::COUNT_W-1:0] r_offsets [qdx4_pkg::NUM_COUNTERS];
    logic [qdx4_pkg::TIME_W-1:0]  r_last_time;
    logic [qdx4_pkg::TIME_W-1:0]  r_period;

    logic [qdx4_pkg::COUNT_W-1:0] n_total;
    logic [qdx4_pkg::TIME_W-1:0]  n_period;
    logic [qdx4_pkg::STATE_W-1:0] cur;
    logic [qdx4_pkg::STATE_W-1:0] diff;
    logic                         valid_edge;
    logic [qdx4_pkg::TIME_W-1:0]  delta;
    logic [qdx4_pkg::COUNT_W-1:0] offs_sel;
    logic                         idx_hit;
    logic [qdx4_pkg::COUNT_W-1:0] rel;

    assign cur  = {i_sample.chan_a, i_sample.chan_b};
    assign diff = cur ^ r_prev;
    // exactly one bit changed; two-bit jumps are dropped
    assign valid_edge = r_primed && (diff[0] ^ diff[1]);
    assign delta      = i_sample.time_us - r_last_time;

    always_comb begin
        n_total  = r_total;
        n_period = r_period;
        if (valid_edge) begin
            if (r_prev[0] == cur[1]) begin
                n_total = r_total + 32'd1;
            end else begin
                n_total = r_total - 32'd1;
            end
            n_period = (delta >> 1) + (r_period >> 1);
        end
    end

    always_comb begin
        offs_sel = '0;
        idx_hit  = 1'b0;
        for (int i = 0; i < qdx4_pkg::NUM_COUNTERS; i++) begin
            if (32'(i_sample.counter_index) == 32'(i)) begin
                offs_sel = r_offsets[i];
                idx_hit  = 1'b1;
            end
        end
    end

    always_comb begin
        if (idx_hit && i_sample.zero_counter) begin
            rel = '0;
        end else begin
            rel = n_total - offs_sel;
        end
    end

    assign o_result.relative_count = rel;
    assign o_result.channel_state  = cur;
    assign o_result.edge_period    = n_period;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '0;
            r_primed    <= 1'b0;
            r_total     <= '0;
            r_last_time <= '0;
            r_period    <= '0;
            for (int i = 0; i < qdx4_pkg::NUM_COUNTERS; i++) begin
                r_offsets[i] <= '0;
            end
        end else if (i_fire) begin
            r_prev   <= cur;
            r_primed <= 1'b1;
            r_total  <= n_total;
            r_period <= n_period;
            if (valid_edge) begin
                r_last_time <= i_sample.time_us;
            end
            for (int i = 0; i < qdx4_pkg::NUM_COUNTERS; i++) begin
                if (i_sample.zero_counter &&
                    32'(i_sample.counter_index) == 32'(i)) begin
                    r_offsets[i] <= n_total;
                end
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/quadrature_decoder_x4_core.sv */
// ----------------------------------------------------------------------------
// quadrature_decoder_x4_core
// x4 quadrature decoder with relative counters and a smoothed edge period.
// ----------------------------------------------------------------------------
// Path: input register, then result register; a transaction waits in the input
//   register only while the result register is full and the output is stalled.
// Throughput: one transaction per cycle while the output is not stalled, set by the single-pass update.
// Reset: synchronous, active low; clears both pipeline valids, the count,
//   the offsets, the period and the priming flag.
// ----------------------------------------------------------------------------
`default_nettype none

module quadrature_decoder_x4_core (
    input  wire                                       i_clk,
    input  wire                                       i_rst_n,
    // sample channel
    input  wire                                       i_in_valid,
    output logic                                      o_in_stall,
    input  wire                                       i_chan_a,
    input  wire                                       i_chan_b,
    input  wire  [qdx4_pkg::TIME_W-1:0]               i_time_us,
    input  wire  [qdx4_pkg::IDX_W-1:0]                i_counter_index,
    input  wire                                       i_zero_counter,
    // result channel
    output logic                                      o_out_valid,
    input  wire                                       i_out_stall,
    output logic signed [qdx4_pkg::COUNT_W-1:0]       o_relative_count,
    output logic [qdx4_pkg::STATE_W-1:0]              o_channel_state,
    output logic [qdx4_pkg::TIME_W-1:0]               o_edge_period
);

    qdx4_pkg::t_sample in_sample;
    qdx4_pkg::t_sample st_sample;
    logic              st_valid;
    qdx4_pkg::t_result upd_result;
    logic              advance;

    logic              r_out_valid;
    logic              n_out_valid;
    qdx4_pkg::t_result r_result;

    assign in_sample.chan_a        = i_chan_a;
    assign in_sample.chan_b        = i_chan_b;
    assign in_sample.time_us       = i_time_us;
    assign in_sample.counter_index = i_counter_index;
    assign in_sample.zero_counter  = i_zero_counter;

    // The held sample moves into the result register (and commits its state
    // update) whenever that register is empty or is being emptied this cycle.
    // The input register therefore only back-pressures when both stages are
    // full and the consumer is stalling.
    assign advance = st_valid && (!r_out_valid || !i_out_stall);

    qdx4_in_stage u_in_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .i_sample (in_sample),
        .i_take   (advance),
        .o_stall  (o_in_stall),
        .o_valid  (st_valid),
        .o_sample (st_sample)
    );

    // Decoder state lives here; it only changes on advance, so a stalled
    // transaction never updates the count twice.
    qdx4_update u_update (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_sample (st_sample),
        .o_result (upd_result)
    );

    // Result register: loaded on advance, cleared once the consumer takes it.
    always_comb begin
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= upd_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_relative_count = r_result.relative_count;
    assign o_channel_state  = r_result.channel_state;
    assign o_edge_period    = r_result.edge_period;

endmodule

`default_nettype wire

/* hdl/qdx4_checker.sv */
// ----------------------------------------------------------------------------
// qdx4_checker
// Port-level checks on the x4 quadrature decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "quadrature_decoder_x4_core_assert.svh"

module qdx4_checker (
    input wire                               i_clk,
    input wire                               i_rst_n,
    input wire                               i_in_valid,
    input wire                               o_in_stall,
    input wire                               i_chan_a,
    input wire                               i_chan_b,
    input wire [qdx4_pkg::TIME_W-1:0]        i_time_us,
    input wire [qdx4_pkg::IDX_W-1:0]         i_counter_index,
    input wire                               i_zero_counter,
    input wire                               o_out_valid,
    input wire                               i_out_stall,
    input wire signed [qdx4_pkg::COUNT_W-1:0] o_relative_count,
    input wire [qdx4_pkg::STATE_W-1:0]       o_channel_state,
    input wire [qdx4_pkg::TIME_W-1:0]        o_edge_period
);

    `QDX4_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid, "result dropped while stalled")
    `QDX4_ASSERT_NEXT(a_out_stable, o_out_valid && i_out_stall, $stable(o_relative_count) && $stable(o_channel_state) && $stable(o_edge_period), "stalled result changed")
    `QDX4_ASSERT_NOW(a_in_stall_cause, o_in_stall, o_out_valid && i_out_stall, "input stalled with free result register")
    `QDX4_ASSERT_ALWAYS(a_reset_empty, !i_rst_n, !o_out_valid && !o_in_stall, "pipeline not empty after reset")

endmodule

bind quadrature_decoder_x4_core qdx4_checker u_qdx4_checker (.*);

`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for quadrature_decoder_x4_core. Samples go in through
// the valid/stall channel, a transaction-level predictor in the bench works out
// every reading, and each result transaction is checked field by field in
// order. Directed edge cases come first, then random encoder motion and
// random glitch noise, with random gaps on the sample side and random stalls
// on the result side.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 3;
    localparam int WATCHDOG_LIMIT = 500;  // quiet cycles before giving up
    localparam int DRAIN_CYCLES   = 8;    // quiet tail after the last reading
    localparam int MAX_REPORTS    = 10;
    localparam int BURST_LEN      = 40;

    // Channel levels as A:B
    localparam logic [1:0] AB_00 = 2'b00;
    localparam logic [1:0] AB_01 = 2'b01;
    localparam logic [1:0] AB_10 = 2'b10;
    localparam logic [1:0] AB_11 = 2'b11;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT ports (all inputs known from time zero)
    // ------------------------------------------------------------------------
    logic                                i_clk           = 1'b0;
    logic                                i_rst_n         = 1'b0;
    logic                                i_in_valid      = 1'b0;
    logic                                i_chan_a        = 1'b0;
    logic                                i_chan_b        = 1'b0;
    logic [qdx4_pkg::TIME_W-1:0]         i_time_us       = '0;
    logic [qdx4_pkg::IDX_W-1:0]          i_counter_index = '0;
    logic                                i_zero_counter  = 1'b0;
    logic                                i_out_stall     = 1'b0;
    logic                                o_in_stall;
    logic                                o_out_valid;
    logic signed [qdx4_pkg::COUNT_W-1:0] o_relative_count;
    logic [qdx4_pkg::STATE_W-1:0]        o_channel_state;
    logic [qdx4_pkg::TIME_W-1:0]         o_edge_period;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    quadrature_decoder_x4_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_chan_a         (i_chan_a),
        .i_chan_b         (i_chan_b),
        .i_time_us        (i_time_us),
        .i_counter_index  (i_counter_index),
        .i_zero_counter   (i_zero_counter),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_relative_count (o_relative_count),
        .o_channel_state  (o_channel_state),
        .o_edge_period    (o_edge_period)
    );

    // ------------------------------------------------------------------------
    // Decoder predictor state - mirrors the block's registers after reset
    // ------------------------------------------------------------------------
    logic [1:0]                   last_ab         = '0;
    bit                           ab_primed       = 1'b0;
    logic [qdx4_pkg::COUNT_W-1:0] total_pulses    = '0;
    logic [qdx4_pkg::COUNT_W-1:0] zero_offsets [qdx4_pkg::NUM_COUNTERS];
    logic [qdx4_pkg::TIME_W-1:0]  last_edge_us    = '0;
    logic [qdx4_pkg::TIME_W-1:0]  smoothed_period = '0;

    qdx4_pkg::t_result pending_readings [$];   // readings owed by the DUT, oldest first

    // run statistics
    int steps_up, steps_down, double_changes, zero_loads, readings_seen;
    int fault_count;

    // idling controls, varied per burst
    bit feed_gaps    = 1'b0;
    bit drain_stalls = 1'b0;

    // encoder walker for the motion phase
    int                          pos_gray;
    logic [qdx4_pkg::TIME_W-1:0] clock_us;

    initial begin
        for (int k = 0; k < qdx4_pkg::NUM_COUNTERS; k++) zero_offsets[k] = '0;
    end

    // One sample through the decoder: count, time the edge, apply the zero
    // request, then form the reading.
    function automatic qdx4_pkg::t_result track_encoder(input qdx4_pkg::t_sample s);
        logic [1:0]                   ab;
        logic [1:0]                   flip;
        logic [qdx4_pkg::TIME_W-1:0]  elapsed;
        logic [qdx4_pkg::COUNT_W-1:0] offset;
        qdx4_pkg::t_result            r;
        ab     = {s.chan_a, s.chan_b};
        flip   = ab ^ last_ab;
        offset = '0;
        if (ab_primed) begin
            if (flip == 2'b01 || flip == 2'b10) begin
                // forward when old B matches new A
                if (last_ab[0] == ab[1]) begin
                    total_pulses = total_pulses + 32'd1;
                    steps_up++;
                end else begin
                    total_pulses = total_pulses - 32'd1;
                    steps_down++;
                end
                elapsed         = s.time_us - last_edge_us;  // wraps
                smoothed_period = (elapsed >> 1) + (smoothed_period >> 1);
                last_edge_us    = s.time_us;
            end else if (flip == 2'b11) begin
                double_changes++;  // skipped, state still taken
            end
        end
        ab_primed = 1'b1;
        last_ab   = ab;
        if (int'(s.counter_index) < qdx4_pkg::NUM_COUNTERS) begin
            if (s.zero_counter) begin
                zero_offsets[s.counter_index] = total_pulses;
                zero_loads++;
            end
            offset = zero_offsets[s.counter_index];
        end
        r.relative_count = total_pulses - offset;
        r.channel_state  = ab;
        r.edge_period    = smoothed_period;
        return r;
    endfunction

    function automatic void flag_fault(input string what, input logic [31:0] want,
                                       input logic [31:0] got);
        if (fault_count < MAX_REPORTS)
            $display("[%0t] mismatch %s: expected 0x%08h, got 0x%08h",
                     $realtime, what, want, got);
        fault_count++;
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: checks result transactions, then predicts from sample
    // transactions. Both sampled at the edge, before the bench's NBAs land.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        qdx4_pkg::t_result want;
        qdx4_pkg::t_sample seen;
        if (i_rst_n) begin
            if (o_out_valid === 1'b1 && !i_out_stall) begin
                readings_seen++;
                if (pending_readings.size() == 0) begin
                    flag_fault("unexpected result", '0, o_relative_count);
                end else begin
                    want = pending_readings.pop_front();
                    if (o_relative_count !== want.relative_count)
                        flag_fault("relative_count", want.relative_count,
                                   o_relative_count);
                    if (o_channel_state !== want.channel_state)
                        flag_fault("channel_state", 32'(want.channel_state),
                                   32'(o_channel_state));
                    if (o_edge_period !== want.edge_period)
                        flag_fault("edge_period", want.edge_period, o_edge_period);
                end
            end
            if (i_in_valid && o_in_stall === 1'b0) begin
                seen.chan_a        = i_chan_a;
                seen.chan_b        = i_chan_b;
                seen.time_us       = i_time_us;
                seen.counter_index = i_counter_index;
                seen.zero_counter  = i_zero_counter;
                pending_readings.push_back(track_encoder(seen));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result side: per transaction, optionally hold stall while stalls are enabled,
    // then release it until a reading is taken.
    // ------------------------------------------------------------------------
    initial begin : result_drain
        int hold;
        wait (i_rst_n === 1'b1);
        forever begin
            hold = drain_stalls ? $urandom_range(0, 7) : 0;
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: a run of cycles with no transaction on either side is a hang.
    // ------------------------------------------------------------------------
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_stall === 1'b0) ||
                (o_out_valid === 1'b1 && !i_out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL quadrature_decoder_x4_core");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sample side: optional gap with valid low, then present the sample and
    // hold it until the transaction completes. Called just after an edge.
    // ------------------------------------------------------------------------
    task automatic send_sample(input logic [1:0] ab,
                               input logic [qdx4_pkg::TIME_W-1:0] stamp,
                               input logic [qdx4_pkg::IDX_W-1:0] idx, input logic zero);
        int gap;
        gap = feed_gaps ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_chan_a        <= ab[1];
        i_chan_b        <= ab[0];
        i_time_us       <= stamp;
        i_counter_index <= idx;
        i_zero_counter  <= zero;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
    endtask

    // A:B levels of a forward quadrature walk, position 0..3
    function automatic logic [1:0] gray_ab(input int pos);
        case (pos & 3)
            0:       return AB_00;
            1:       return AB_01;
            2:       return AB_11;
            default: return AB_10;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Priming, no-change, double-change, both directions, timestamp wrap,
    // zero requests on every counter, all-ones and all-zeros fields.
    task automatic test_directed_edges();
        feed_gaps    = 1'b0;
        drain_stalls = 1'b0;
        send_sample(AB_11, 32'hFFFF_FFFF, 2'd3, 1'b1);  // primes only, zero at 0
        send_sample(AB_11, 32'h0000_0005, 2'd0, 1'b0);  // no change
        send_sample(AB_10, 32'h0000_0010, 2'd0, 1'b0);  // first timed edge
        send_sample(AB_01, 32'h0000_0020, 2'd1, 1'b0);  // both bits flip
        send_sample(AB_00, 32'hFFFF_FFFF, 2'd2, 1'b0);  // huge interval
        send_sample(AB_00, 32'h0000_0000, 2'd1, 1'b1);  // zero counter 1
        send_sample(AB_01, 32'h0000_0000, 2'd1, 1'b0);  // stamp wraps round
        send_sample(AB_11, 32'h0000_0064, 2'd1, 1'b0);
        send_sample(AB_10, 32'h0000_00C8, 2'd2, 1'b1);
        send_sample(AB_00, 32'h0000_012C, 2'd3, 1'b0);
        // reverse run drives the total below zero
        send_sample(AB_10, 32'h0000_0136, 2'd2, 1'b0);
        send_sample(AB_11, 32'h0000_0140, 2'd0, 1'b0);
        send_sample(AB_01, 32'h0000_014A, 2'd1, 1'b0);
        send_sample(AB_00, 32'h0000_0154, 2'd3, 1'b0);
        send_sample(AB_10, 32'h0000_015E, 2'd0, 1'b0);
        send_sample(AB_11, 32'h0000_0168, 2'd0, 1'b0);
        send_sample(AB_01, 32'h0000_0172, 2'd0, 1'b0);
        send_sample(AB_00, 32'h0000_017C, 2'd0, 1'b1);
        send_sample(AB_11, 32'h0000_0186, 2'd0, 1'b0);  // both bits flip
        send_sample(AB_00, 32'h0000_0190, 2'd3, 1'b1);  // and back
        send_sample(AB_01, 32'hFFFF_FFFF, 2'd3, 1'b0);
        send_sample(AB_00, 32'h7FFF_FFFF, 2'd0, 1'b0);
        send_sample(AB_00, 32'h8000_0000, 2'd2, 1'b1);
    endtask

    // Well-formed encoder motion: mostly single steps with a per-burst drift,
    // some dwell and some skipped states, plausible timestamps.
    task automatic test_encoder_motion(input int n_bursts);
        int fwd_bias, roll, n;
        logic [qdx4_pkg::IDX_W-1:0] idx;
        logic                       zero;
        pos_gray = int'(last_ab == AB_01) + 2 * int'(last_ab == AB_11)
                   + 3 * int'(last_ab == AB_10);
        clock_us = $urandom();
        for (int b = 0; b < n_bursts; b++) begin
            feed_gaps    = ($urandom_range(0, 3) != 0);
            drain_stalls = ($urandom_range(0, 3) != 0);
            fwd_bias     = $urandom_range(10, 90);
            for (n = 0; n < BURST_LEN; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 8)
                    ;                                // dwell
                else if (roll < 13)
                    pos_gray += 2;                   // missed state
                else if ($urandom_range(0, 99) < fwd_bias)
                    pos_gray += 1;
                else
                    pos_gray += 3;                   // one step back
                pos_gray &= 3;
                if ($urandom_range(0, 19) == 0)
                    clock_us = clock_us + $urandom();
                else
                    clock_us = clock_us + $urandom_range(1, 5000);
                idx  = qdx4_pkg::IDX_W'($urandom_range(0, qdx4_pkg::NUM_COUNTERS - 1));
                zero = ($urandom_range(0, 9) == 0);
                send_sample(gray_ab(pos_gray), clock_us, idx, zero);
            end
        end
    endtask

    // Glitchy input: every field fully random.
    task automatic test_glitch_noise(input int n_bursts);
        for (int b = 0; b < n_bursts; b++) begin
            feed_gaps    = ($urandom_range(0, 1) != 0);
            drain_stalls = ($urandom_range(0, 1) != 0);
            for (int n = 0; n < BURST_LEN; n++)
                send_sample(2'($urandom_range(0, 3)), $urandom(),
                            2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    initial begin : sequencer
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_edges();
        test_encoder_motion(15);
        test_glitch_noise(5);

        // stimulus done: let every reading come back, then a short quiet tail
        i_in_valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d readings: %0d forward and %0d reverse edges,",
                 readings_seen, steps_up, steps_down);
        $display("%0d double changes skipped, %0d counter zero loads, %0d mismatches",
                 double_changes, zero_loads, fault_count);
        if (fault_count == 0)
            $display("PASS quadrature_decoder_x4_core");
        else
            $display("FAIL quadrature_decoder_x4_core");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+hdl
hdl/qdx4_pkg.sv
hdl/qdx4_in_stage.sv
hdl/qdx4_update.sv
hdl/quadrature_decoder_x4_core.sv
hdl/qdx4_checker.sv
tb/sv/tb_top.sv
